FILE: sv/atws_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the autobaud text window scorer.
// No dependencies; every other file imports this package.
package atws_pkg;

  // Sizes
  localparam int WINDOW_BYTES = 256;
  localparam int NUM_RATES    = 6;
  localparam int CNT_W        = $clog2(WINDOW_BYTES + 1);
  localparam int SCORE_W      = 19;
  localparam int RATE_W       = 3;
  localparam int BYTE_W       = 8;
  localparam int OP_W         = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 19;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Divider: printable*800/len, quotient never above 800
  localparam int BASE_SCALE = 800;
  localparam int QUO_W      = 10;
  localparam int NUM_W      = CNT_W + QUO_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [RATE_W-1:0]         rate_t;
  typedef logic [BYTE_W-1:0]         byte_t;
  typedef logic [QUO_W-1:0]          quo_t;
  typedef logic [NUM_W-1:0]          num_t;

  // Scores in 1/16 units
  localparam score_t SCORE_EMPTY       = -19'sd159984;
  localparam score_t SCORE_SHORT       = -19'sd1600;
  localparam score_t SCORE_INIT        = -19'sd15984;
  localparam score_t RUN_BONUS         = 19'sd320;
  localparam score_t LINE_BONUS        = 19'sd240;
  localparam score_t NUL_PENALTY       = 19'sd480;
  localparam score_t LOW_RATIO_PENALTY = 19'sd640;
  localparam score_t ACCEPT_RESET      = 19'sd1040;
  localparam score_t FLOOR_RESET       = -19'sd320;
  localparam cnt_t   LONG_RUN_RESET    = CNT_W'(6);
  localparam cnt_t   MIN_LOCK_BYTES    = CNT_W'(4);
  localparam cnt_t   MIN_SCORE_BYTES   = CNT_W'(3);
  localparam cnt_t   WINDOW_LIMIT      = CNT_W'(WINDOW_BYTES);
  localparam logic [RATE_W:0] RATE_LIMIT = (RATE_W + 1)'(NUM_RATES);

  // Character codes
  localparam byte_t CH_NUL   = 8'h00;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TILDE = 8'h7E;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE = 2'd0,
    OP_END  = 2'd1,
    OP_SCAN = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEPT_SCORE = 2'd0,
    CFG_LONG_RUN_MIN = 2'd1,
    CFG_FINAL_FLOOR  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SCORE
  } back_state_t;

  // One queued command: a closed window or a new-scan marker
  typedef struct packed {
    logic  is_scan;
    cnt_t  len;
    cnt_t  printable;
    cnt_t  longest;
    logic  line_end;
    logic  nul;
    rate_t rate;
  } q_entry_t;

  typedef struct packed {
    score_t accept_score;
    cnt_t   long_run_min;
    score_t final_floor;
  } cfg_t;

  function automatic logic is_printable(input byte_t b);
    return (b >= CH_SPACE && b <= CH_TILDE) || b == CH_CR || b == CH_LF || b == CH_TAB;
  endfunction

endpackage

FILE: sv/atws_in_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one command word.
// Depends on atws_pkg.
interface atws_in_if;
  import atws_pkg::*;

  logic  valid;
  logic  ready;
  logic [OP_W-1:0] opcode;
  byte_t data_byte;
  rate_t rate_index;

  modport source (output valid, output opcode, output data_byte, output rate_index,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input rate_index,
                output ready);
endinterface

FILE: sv/atws_out_if.sv
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying one window result word.
// Depends on atws_pkg.
interface atws_out_if;
  import atws_pkg::*;

  logic   valid;
  logic   ready;
  score_t window_score;
  cnt_t   window_bytes;
  logic   locked;
  rate_t  best_rate_index;
  score_t top_score;
  logic   rate_found;

  modport source (output valid, output window_score, output window_bytes, output locked,
                  output best_rate_index, output top_score, output rate_found,
                  input ready);
  modport sink (input valid, input window_score, input window_bytes, input locked,
                input best_rate_index, input top_score, input rate_found,
                output ready);
endinterface

FILE: sv/atws_front.sv
`timescale 1ns / 1ps
// Front end: takes command words, keeps the per-window byte statistics and
// queues closed windows and new-scan markers. Depends on atws_pkg, atws_in_if.
module atws_front (
  input  logic               clk,
  input  logic               rst,
  atws_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               push,
  output atws_pkg::q_entry_t push_entry
);
  import atws_pkg::*;

  cnt_t byte_total;
  cnt_t printable_total;
  cnt_t current_run;
  cnt_t longest_run;
  logic saw_line_end;
  logic saw_nul;

  logic  accept;
  op_t   op;
  byte_t b;
  logic  take_byte;
  logic  printable;
  cnt_t  run_inc;

  // Every opcode waits for queue room, so ordering is never broken
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign op          = op_t'(in_ch.opcode);
  assign b           = in_ch.data_byte;
  assign printable   = is_printable(b);
  assign run_inc     = current_run + CNT_W'(1);
  assign take_byte   = accept && op == OP_BYTE && byte_total < WINDOW_LIMIT;

  // Window end and new scan both go to the back end in order
  assign push = accept && (op == OP_END || op == OP_SCAN);

  always_comb begin
    push_entry.is_scan   = (op == OP_SCAN);
    push_entry.len       = byte_total;
    push_entry.printable = printable_total;
    push_entry.longest   = longest_run;
    push_entry.line_end  = saw_line_end;
    push_entry.nul       = saw_nul;
    push_entry.rate      = in_ch.rate_index;
  end

  // Window statistics
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_total      <= '0;
      printable_total <= '0;
      current_run     <= '0;
      longest_run     <= '0;
      saw_line_end    <= 1'b0;
      saw_nul         <= 1'b0;
    end else if (take_byte) begin
      byte_total <= byte_total + CNT_W'(1);
      if (printable) begin
        printable_total <= printable_total + CNT_W'(1);
        current_run     <= run_inc;
        if (run_inc > longest_run) begin
          longest_run <= run_inc;
        end
      end else begin
        current_run <= '0;
      end
      if (b == CH_LF || b == CH_CR) begin
        saw_line_end <= 1'b1;
      end
      if (b == CH_NUL) begin
        saw_nul <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/atws_queue.sv
`timescale 1ns / 1ps
// Short FIFO of window records between front and back end.
// Depends on atws_pkg.
module atws_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  atws_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               head_valid,
  output atws_pkg::q_entry_t head,
  output logic               full
);
  import atws_pkg::*;

  q_entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;

  assign head_valid = (count != '0);
  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head       = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: sv/atws_back.sv
`timescale 1ns / 1ps
// Back end: restoring divider for the printable ratio, score terms, best
// candidate tracking and the output register. Depends on atws_pkg, atws_out_if.
module atws_back (
  input  logic               clk,
  input  logic               rst,
  input  atws_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  atws_pkg::q_entry_t head,
  output logic               pop,
  atws_out_if.source         out_ch
);
  import atws_pkg::*;

  back_state_t state;
  back_state_t state_next;

  // Window being scored
  q_entry_t cur;

  // Divider
  cnt_t                 rem;
  quo_t                 quo;
  quo_t                 num_lo;
  logic [DIV_CNT_W-1:0] div_cnt;
  num_t                 num;
  logic [CNT_W:0]       trial;
  logic                 trial_ok;

  // Best candidate
  score_t best_so_far;
  rate_t  best_index;
  logic   have_best;
  logic   lock_flag;

  // Output register
  logic   out_valid;
  score_t out_score;
  cnt_t   out_bytes;
  logic   out_locked;
  rate_t  out_best_index;
  score_t out_top_score;
  logic   out_found;

  logic   load_div;
  logic   div_step;
  logic   fire;
  logic   out_free;
  logic   clear_best;

  score_t score;
  score_t best_n;
  rate_t  index_n;
  logic   have_n;
  logic   lock_n;
  logic   found_n;
  logic   eligible;

  assign out_free = !out_valid || out_ch.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (head_valid && !head.is_scan) begin
          state_next = (head.len >= MIN_SCORE_BYTES) ? B_DIV : B_SCORE;
        end
      end
      B_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = B_SCORE;
        end
      end
      B_SCORE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop        = 1'b0;
    load_div   = 1'b0;
    div_step   = 1'b0;
    fire       = 1'b0;
    clear_best = 1'b0;
    unique case (state)
      B_IDLE: begin
        pop        = head_valid;
        load_div   = head_valid && !head.is_scan;
        clear_best = head_valid && head.is_scan;
      end
      B_DIV:   div_step = 1'b1;
      B_SCORE: fire     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider: the high part of printable*800 is already below len, so ten
  // quotient bits remain, one per cycle
  assign num      = NUM_W'(head.printable) * NUM_W'(BASE_SCALE);
  assign trial    = {rem, num_lo[QUO_W-1]} - {1'b0, cur.len};
  assign trial_ok = !trial[CNT_W];

  always_ff @(posedge clk) begin
    if (load_div) begin
      cur     <= head;
      rem     <= num[NUM_W-1:QUO_W];
      num_lo  <= num[QUO_W-1:0];
      quo     <= '0;
      div_cnt <= '0;
    end else if (div_step) begin
      rem     <= trial_ok ? trial[CNT_W-1:0] : {rem[CNT_W-2:0], num_lo[QUO_W-1]};
      quo     <= {quo[QUO_W-2:0], trial_ok};
      num_lo  <= {num_lo[QUO_W-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // Window score
  always_comb begin
    if (cur.len == '0) begin
      score = SCORE_EMPTY;
    end else if (cur.len < MIN_SCORE_BYTES) begin
      score = SCORE_SHORT;
    end else begin
      score = SCORE_W'(quo);
      if (cur.longest > cfg.long_run_min) begin
        score = score + RUN_BONUS;
      end
      if (cur.line_end) begin
        score = score + LINE_BONUS;
      end
      if (cur.nul) begin
        score = score - NUL_PENALTY;
      end
      if ({cur.printable, 1'b0} < {1'b0, cur.len}) begin
        score = score - LOW_RATIO_PENALTY;
      end
    end
  end

  // Best update
  assign eligible = !lock_flag && ({1'b0, cur.rate} < RATE_LIMIT);

  always_comb begin
    best_n  = best_so_far;
    index_n = best_index;
    have_n  = have_best;
    lock_n  = lock_flag;
    if (eligible) begin
      if (score > cfg.accept_score && cur.len >= MIN_LOCK_BYTES) begin
        best_n  = score;
        index_n = cur.rate;
        have_n  = 1'b1;
        lock_n  = 1'b1;
      end else if (score > best_so_far && cur.len != '0) begin
        best_n  = score;
        index_n = cur.rate;
        have_n  = 1'b1;
      end
    end
    found_n = have_n && (best_n > cfg.final_floor);
  end

  always_ff @(posedge clk) begin
    if (rst || clear_best) begin
      best_so_far <= SCORE_INIT;
      best_index  <= '0;
      have_best   <= 1'b0;
      lock_flag   <= 1'b0;
    end else if (fire) begin
      best_so_far <= best_n;
      best_index  <= index_n;
      have_best   <= have_n;
      lock_flag   <= lock_n;
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_score      <= score;
      out_bytes      <= cur.len;
      out_locked     <= lock_n;
      out_best_index <= index_n;
      out_top_score  <= best_n;
      out_found      <= found_n;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.window_score    = out_score;
  assign out_ch.window_bytes    = out_bytes;
  assign out_ch.locked          = out_locked;
  assign out_ch.best_rate_index = out_best_index;
  assign out_ch.top_score       = out_top_score;
  assign out_ch.rate_found      = out_found;

endmodule

FILE: sv/autobaud_text_window_scorer_core.sv
`timescale 1ns / 1ps
// Top level of the autobaud text window scorer: configuration registers,
// front end, window queue and back end. Depends on atws_pkg and all atws_* files.
//
// Usage:
//   in_ch carries command words: opcode 0 counts data_byte into the open
//   window (bytes past 256 are dropped), opcode 1 closes the window for
//   candidate rate_index, opcode 2 starts a new scan and clears the best
//   candidate, opcode 3 does nothing. Only opcode 1 makes a result word.
//   out_ch carries the window score, its byte count and the best-so-far view.
//   cfg_we/cfg_index/cfg_data write accept_score (0), long_run_min (1) and
//   final_floor (2); change them only while no window is in flight.
// Timing:
//   One command word per cycle while the two-entry window queue has room.
//   A closed window of three or more bytes passes through the back end in
//   order: dequeue, the bit-per-cycle divider for printable*800/len, then
//   score and best update once the output register is free; shorter
//   windows skip the divider. The result then sits in the output register.
//   A stalled out_ch holds the result; the back end then holds one more
//   window and the queue two more window ends before in_ch drops ready.
//   Byte words keep flowing until then.
// Reset: synchronous; clears counters, best candidate, lock and the queue,
//   and loads the register defaults (1040, 6, -320).
module autobaud_text_window_scorer_core (
  input  logic                               clk,
  input  logic                               rst,
  atws_in_if.sink                            in_ch,
  atws_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [atws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [atws_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import atws_pkg::*;

  cfg_t     cfg;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  logic     head_valid;
  q_entry_t head;
  logic     q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accept_score <= ACCEPT_RESET;
      cfg.long_run_min <= LONG_RUN_RESET;
      cfg.final_floor  <= FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACCEPT_SCORE: cfg.accept_score <= score_t'(cfg_data);
        CFG_LONG_RUN_MIN: cfg.long_run_min <= cfg_data[CNT_W-1:0];
        CFG_FINAL_FLOOR:  cfg.final_floor  <= score_t'(cfg_data);
        default: ;
      endcase
    end
  end

  atws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  atws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (q_full)
  );

  atws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

`ifndef ASSERT_OFF
  // Front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("window queue overflow");

  // Queue is never popped when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("window queue underflow");

  // Byte count of a result never exceeds the window size
  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.window_bytes <= WINDOW_LIMIT)
    else $error("window byte count out of range");

  // Best candidate always names a real rate
  a_best_index: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ({1'b0, out_ch.best_rate_index} < RATE_LIMIT))
    else $error("best rate index out of range");
`endif

endmodule
